### hw/rtl/scbr_pkg.sv
// Shared types and constants for the staged-commit byte ring.
// Holds the operation codes, the controller state encoding and the bank layout.
// No dependencies.
package scbr_pkg;

    // Byte banks across one memory row. A contiguous run of up to eight
    // addresses touches every bank at most once.
    localparam int BANKS  = 8;
    localparam int BANK_W = 3;

    // Largest ring size that the 12-bit pointers and amount field allow.
    localparam int SIZE_CAP = 4096;

    localparam int CNT_W  = 4;
    localparam int DATA_W = 64;
    localparam int AMT_W  = 12;
    localparam int CFG_W  = 13;

    typedef enum logic [2:0] {
        OP_ENQ_SPACE  = 3'd0,
        OP_ENQ_SEG    = 3'd1,
        OP_ENQ_COMMIT = 3'd2,
        OP_ENQ_RESET  = 3'd3,
        OP_DEQ_SPACE  = 3'd4,
        OP_DEQ_SEG    = 3'd5,
        OP_DEQ_COMMIT = 3'd6,
        OP_DEQ_RESET  = 3'd7
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WRAP = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

endpackage

### hw/rtl/staged_commit_byte_ring.sv
// Staged-commit byte ring: top level with the banked byte store and its controller.
// Depends on scbr_pkg for operation codes, state encoding and bank layout.
//
// Usage:
//   Requests enter on the input channel (in_valid / in_stall) carrying op,
//   byte_count and in_bytes. Each request yields exactly one result on the
//   output channel (out_valid / out_stall) carrying status, amount, out_bytes.
//   The ring size is written on the cfg channel (cfg_valid / cfg_ready); a
//   write empties the ring and is to be done only while the block is idle.
//   A request passes from acceptance through the execute state to the finish
//   state, with a wrap state between them when a segment wraps past the end of
//   the ring, because the byte store is one row access per cycle and a wrapped
//   segment needs two row accesses. A new request is accepted the cycle after
//   a result is loaded, so the block takes no new request while one is in flight.
//   A finished result waits in the output register while out_stall is high;
//   the next request is still accepted and waits in its last stage until the
//   output register frees up.
//   Reset empties the ring (all pointers zero), sets the size to the largest
//   the store allows, and drops any pending result. Store contents are not
//   cleared; only written bytes are ever read back.
module staged_commit_byte_ring #(
    parameter int RING_DEPTH    = 4096,
    parameter int SEGMENT_BYTES = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  op,
    input  logic [scbr_pkg::CNT_W-1:0]  byte_count,
    input  logic [scbr_pkg::DATA_W-1:0] in_bytes,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        status,
    output logic [scbr_pkg::AMT_W-1:0]  amount,
    output logic [scbr_pkg::DATA_W-1:0] out_bytes,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [scbr_pkg::CFG_W-1:0]  ring_size
);
    import scbr_pkg::*;

    localparam int CAP   = (RING_DEPTH < SIZE_CAP) ? RING_DEPTH : SIZE_CAP;
    localparam int PTR_W = $clog2(CAP);
    localparam int SZ_W  = PTR_W + 1;
    localparam int ROW_W = PTR_W - BANK_W;
    localparam int ROWS  = (CAP + BANKS - 1) / BANKS;

    function automatic logic [SZ_W-1:0] ring_dist(input logic [PTR_W-1:0] a,
                                                  input logic [PTR_W-1:0] b,
                                                  input logic [SZ_W-1:0] size);
        logic [SZ_W-1:0] ax;
        logic [SZ_W-1:0] bx;
        ax = {1'b0, a};
        bx = {1'b0, b};
        return (ax >= bx) ? (ax - bx) : (ax + size - bx);
    endfunction

    // Control state
    state_t            state_reg, state_next;
    logic [SZ_W-1:0]   size_reg, size_next;
    logic [PTR_W-1:0]  ch_reg, ch_next;
    logic [PTR_W-1:0]  ct_reg, ct_next;
    logic [PTR_W-1:0]  th_reg, th_next;
    logic [PTR_W-1:0]  tt_reg, tt_next;
    logic              out_valid_reg, out_valid_next;

    // Request and result payload
    logic [2:0]               op_reg, op_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [DATA_W-1:0]        data_reg, data_next;
    logic [PTR_W-1:0]         start_reg, start_next;
    logic [CNT_W-1:0]         n1_reg, n1_next;
    logic                     wrap_reg, wrap_next;
    logic                     rd_op_reg, rd_op_next;
    logic                     res_status_reg, res_status_next;
    logic [AMT_W-1:0]         res_amount_reg, res_amount_next;
    logic [BANKS-1:0][7:0]    piece1_reg, piece1_next;
    logic                     status_reg, status_next;
    logic [AMT_W-1:0]         amount_reg, amount_next;
    logic [DATA_W-1:0]        out_bytes_reg, out_bytes_next;

    // Store access for the current cycle
    logic              acc_we;
    logic              acc_re;
    logic [PTR_W-1:0]  acc_start;
    logic [CNT_W-1:0]  acc_len;
    logic [CNT_W-1:0]  acc_base;
    logic [BANKS-1:0][7:0] rd_data;

    // Datapath for the request being executed
    logic [SZ_W-1:0]   enq_space;
    logic [SZ_W-1:0]   deq_space;
    logic [SZ_W-1:0]   seg_space;
    logic [SZ_W-1:0]   cnt_ext;
    logic [PTR_W-1:0]  seg_ptr;
    logic [SZ_W-1:0]   room;
    logic [SZ_W-1:0]   adv_sum;
    logic [PTR_W-1:0]  adv_ptr;
    logic              seg_wraps;
    logic              seg_refused;
    logic [BANKS-1:0][7:0] gath1;
    logic [BANKS-1:0][7:0] gath_fin;
    logic              out_free;
    logic [SZ_W-1:0]   cfg_size;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign amount    = amount_reg;
    assign out_bytes = out_bytes_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // The size in effect is the written value clamped to the usable range.
    always_comb
    begin
        if (ring_size < CFG_W'(2))
            cfg_size = SZ_W'(2);
        else if (ring_size > CFG_W'(CAP))
            cfg_size = SZ_W'(CAP);
        else
            cfg_size = ring_size[SZ_W-1:0];
    end

    assign enq_space = size_reg - SZ_W'(1) - ring_dist(tt_reg, ch_reg, size_reg);
    assign deq_space = ring_dist(ct_reg, th_reg, size_reg);
    assign seg_space = op_reg[2] ? deq_space : enq_space;
    assign seg_ptr   = op_reg[2] ? th_reg : tt_reg;
    assign cnt_ext   = SZ_W'(cnt_reg);
    assign room      = size_reg - {1'b0, seg_ptr};
    assign seg_wraps = cnt_ext > room;
    assign adv_sum   = {1'b0, seg_ptr} + cnt_ext;
    assign adv_ptr   = (adv_sum >= size_reg) ? PTR_W'(adv_sum - size_reg) : PTR_W'(adv_sum);
    assign seg_refused = (cnt_reg > CNT_W'(SEGMENT_BYTES)) || (cnt_ext > seg_space);

    // Byte-banked store: a run of up to eight consecutive addresses is one access.
    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        logic [BANK_W-1:0] k;
        logic              en;
        logic [ROW_W-1:0]  row;
        logic [CNT_W-1:0]  idx;
        logic [7:0]        bank_mem [ROWS];
        logic [7:0]        rd_q;

        assign k   = BANK_W'(b) - acc_start[BANK_W-1:0];
        assign en  = {1'b0, k} < acc_len;
        assign row = acc_start[PTR_W-1:BANK_W]
                   + ROW_W'(BANK_W'(b) < acc_start[BANK_W-1:0]);
        assign idx = acc_base + {1'b0, k};

        always_ff @(posedge clk)
        begin
            if (acc_we && en)
                bank_mem[row] <= data_reg[{idx[BANK_W-1:0], 3'b000} +: 8];
            if (acc_re && en)
                rd_q <= bank_mem[row];
        end

        assign rd_data[b] = rd_q;
    end

    // Reorder read bytes into segment order. The first piece starts at the
    // segment pointer; the wrapped piece starts at address zero.
    always_comb
    begin
        logic [BANK_W-1:0] i1;
        logic [BANK_W-1:0] i2;
        logic [7:0]        p1;
        for (int i = 0; i < BANKS; i++)
        begin
            i1 = start_reg[BANK_W-1:0] + BANK_W'(i);
            i2 = BANK_W'(i) - n1_reg[BANK_W-1:0];
            gath1[i] = rd_data[i1];
            p1 = wrap_reg ? piece1_reg[i] : rd_data[i1];
            if (CNT_W'(i) >= cnt_reg)
                gath_fin[i] = 8'h00;
            else if (CNT_W'(i) < n1_reg)
                gath_fin[i] = p1;
            else
                gath_fin[i] = rd_data[i2];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        size_next       = size_reg;
        ch_next         = ch_reg;
        ct_next         = ct_reg;
        th_next         = th_reg;
        tt_next         = tt_reg;
        out_valid_next  = out_valid_reg;
        op_next         = op_reg;
        cnt_next        = cnt_reg;
        data_next       = data_reg;
        start_next      = start_reg;
        n1_next         = n1_reg;
        wrap_next       = wrap_reg;
        rd_op_next      = rd_op_reg;
        res_status_next = res_status_reg;
        res_amount_next = res_amount_reg;
        piece1_next     = piece1_reg;
        status_next     = status_reg;
        amount_next     = amount_reg;
        out_bytes_next  = out_bytes_reg;
        acc_we          = 1'b0;
        acc_re          = 1'b0;
        acc_start       = seg_ptr;
        acc_len         = '0;
        acc_base        = '0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    cnt_next   = byte_count;
                    data_next  = in_bytes;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_status_next = 1'b0;
                res_amount_next = '0;
                rd_op_next      = 1'b0;
                wrap_next       = 1'b0;
                start_next      = seg_ptr;
                n1_next         = seg_wraps ? room[CNT_W-1:0] : cnt_reg;
                state_next      = S_FIN;
                case (op_t'(op_reg))
                    OP_ENQ_SPACE:  res_amount_next = AMT_W'(enq_space);
                    OP_DEQ_SPACE:  res_amount_next = AMT_W'(deq_space);
                    OP_ENQ_COMMIT: ct_next = tt_reg;
                    OP_ENQ_RESET:  tt_next = ct_reg;
                    OP_DEQ_COMMIT: ch_next = th_reg;
                    OP_DEQ_RESET:  th_next = ch_reg;
                    OP_ENQ_SEG, OP_DEQ_SEG:
                    begin
                        if (seg_refused)
                            res_status_next = 1'b1;
                        else
                        begin
                            res_amount_next = AMT_W'(cnt_reg);
                            if (op_reg[2])
                                th_next = adv_ptr;
                            else
                                tt_next = adv_ptr;
                            if (cnt_reg != '0)
                            begin
                                acc_we     = !op_reg[2];
                                acc_re     = op_reg[2];
                                acc_len    = seg_wraps ? room[CNT_W-1:0] : cnt_reg;
                                rd_op_next = op_reg[2];
                                wrap_next  = seg_wraps;
                                if (seg_wraps)
                                    state_next = S_WRAP;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_WRAP:
            begin
                // Second access for the part of the segment past the ring end.
                acc_we      = !rd_op_reg;
                acc_re      = rd_op_reg;
                acc_start   = '0;
                acc_base    = n1_reg;
                acc_len     = cnt_reg - n1_reg;
                piece1_next = gath1;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    amount_next    = res_amount_reg;
                    out_bytes_next = rd_op_reg ? DATA_W'(gath_fin) : '0;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // A size write empties the ring; the user is to write it only while idle, the block does not enforce it.
        if (cfg_valid && cfg_ready)
        begin
            size_next = cfg_size;
            ch_next   = '0;
            ct_next   = '0;
            th_next   = '0;
            tt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= SZ_W'(CAP);
            ch_reg        <= '0;
            ct_reg        <= '0;
            th_reg        <= '0;
            tt_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            ch_reg        <= ch_next;
            ct_reg        <= ct_next;
            th_reg        <= th_next;
            tt_reg        <= tt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        cnt_reg        <= cnt_next;
        data_reg       <= data_next;
        start_reg      <= start_next;
        n1_reg         <= n1_next;
        wrap_reg       <= wrap_next;
        rd_op_reg      <= rd_op_next;
        res_status_reg <= res_status_next;
        res_amount_reg <= res_amount_next;
        piece1_reg     <= piece1_next;
        status_reg     <= status_next;
        amount_reg     <= amount_next;
        out_bytes_reg  <= out_bytes_next;
    end

endmodule
